### rtl/srtf_pkg.sv
// Package for the shortest-remaining-time scheduler core.
// Holds field widths, the operation codes, the slot entry and result layouts.
// No dependencies.
package srtf_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int JOB_W     = 8;
  localparam int TIME_W    = 16;
  localparam int SLICE_W   = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd1;

  // Codes carried on in_tuser.
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // One slot of the job table as kept in memory.
  typedef struct packed {
    logic              started;
    logic [JOB_W-1:0]  job;
    logic [TIME_W-1:0] remaining;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Result word, lowest field in the lowest bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic [TIME_W-1:0] remaining_after;
    logic              finished;
    logic              first_run;
    logic              switched;
    logic [JOB_W-1:0]  run_id;
    logic              busy_res;
    logic              accepted;
  } srtf_result_t;

endpackage

### rtl/srtf_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Used for the job table of the scheduler; no dependencies.
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/shortest_remaining_time_scheduler_core.sv
// Top level of the shortest-remaining-time scheduler core.
// Depends on srtf_pkg and srtf_ram.
//
// The core keeps a table of SLOTS jobs and handles one input word at a time.
// An arrival word (in_tuser = 0) stores a job in the lowest free slot. This
// walks the slot valid bits one per cycle up to the first free slot. A tick
// word (in_tuser = 1) walks all SLOTS table entries through the single read
// port of the table memory, one per cycle. It compares each remaining time
// against the best so far in one shared comparator. The input is ready
// again as soon as the result has moved into the output register, so a new
// word may be taken while a result still waits. A result that is still held
// in the output register stalls the next completion until it is taken. The
// slice length is written through cfg_wr_en / cfg_wr_data and should be
// changed only while the core is idle.
module shortest_remaining_time_scheduler_core #(
  parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input words.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] job_id, [23:8] run_time
  input  logic [srtf_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                            in_tuser,
  // Result words.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] accepted, [1] busy_res, [9:2] run_id, [10] switched, [11] first_run,
  // [12] finished, [28:13] remaining_after, [31:29] zero
  output logic [srtf_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration.
  input  logic                            cfg_wr_en,
  input  logic [srtf_pkg::SLICE_W-1:0]    cfg_wr_data
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN_A = 3'd1;
  localparam logic [2:0] ST_A_DONE = 3'd2;
  localparam logic [2:0] ST_SCAN_T = 3'd3;
  localparam logic [2:0] ST_T_DONE = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [IW-1:0]                  idx_r, idx_nxt;
  logic                           issue_done_r, issue_done_nxt;
  logic                           rd_v_r, rd_v_nxt;
  logic [IW-1:0]                  rd_idx_r;
  logic                           found_r, found_nxt;
  logic [IW-1:0]                  best_idx_r, best_idx_nxt;
  srtf_pkg::slot_entry_t          best_r, best_nxt;
  logic [SLOTS-1:0]               valid_r, valid_nxt;
  logic [srtf_pkg::JOB_W-1:0]     prev_job_r, prev_job_nxt;
  logic                           prev_known_r, prev_known_nxt;
  logic [srtf_pkg::SLICE_W-1:0]   quantum_r;
  logic [srtf_pkg::JOB_W-1:0]     item_job_r;
  logic [srtf_pkg::TIME_W-1:0]    item_time_r;
  logic                           out_valid_r, out_valid_nxt;
  srtf_pkg::srtf_result_t         out_data_r, out_data_nxt;

  logic                           in_fire;
  logic                           can_out;
  logic                           take;
  logic [srtf_pkg::TIME_W-1:0]    slice_ext;
  logic [srtf_pkg::TIME_W-1:0]    rem_new;
  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  srtf_pkg::slot_entry_t          ram_wdata;
  srtf_pkg::slot_entry_t          ram_rdata;

  srtf_ram #(
    .WIDTH (srtf_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign can_out    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Shared comparator: the entry coming out of memory against the best so far.
  assign take = rd_v_r && valid_r[rd_idx_r] &&
                (!found_r || (ram_rdata.remaining < best_r.remaining));

  assign slice_ext = srtf_pkg::TIME_W'(quantum_r);
  assign rem_new   = (best_r.remaining > slice_ext) ?
                     (best_r.remaining - slice_ext) : '0;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    rd_v_nxt       = 1'b0;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    valid_nxt      = valid_r;
    prev_job_nxt   = prev_job_r;
    prev_known_nxt = prev_known_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = best_idx_r;
    ram_wdata      = best_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          state_nxt      = (in_tuser == srtf_pkg::FUNC_TICK) ? ST_SCAN_T : ST_SCAN_A;
        end
      end

      ST_SCAN_A: begin
        if (!valid_r[idx_r]) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          state_nxt    = ST_A_DONE;
        end else if (idx_r == LAST) begin
          state_nxt = ST_A_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_A_DONE: begin
        if (can_out) begin
          if (found_r) begin
            ram_we            = 1'b1;
            ram_wdata.started   = 1'b0;
            ram_wdata.job       = item_job_r;
            ram_wdata.remaining = item_time_r;
            valid_nxt[best_idx_r] = 1'b1;
          end
          out_data_nxt          = '0;
          out_data_nxt.accepted = found_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end

      ST_SCAN_T: begin
        // Reads are issued one slot per cycle; data returns in the following cycle.
        if (!issue_done_r) begin
          rd_v_nxt = 1'b1;
          if (idx_r == LAST) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = ram_rdata;
        end
        if (rd_v_r && (rd_idx_r == LAST)) begin
          state_nxt = ST_T_DONE;
        end
      end

      ST_T_DONE: begin
        if (can_out) begin
          out_data_nxt = '0;
          if (found_r) begin
            ram_we              = 1'b1;
            ram_wdata.started   = 1'b1;
            ram_wdata.job       = best_r.job;
            ram_wdata.remaining = rem_new;
            if (rem_new == '0) begin
              valid_nxt[best_idx_r] = 1'b0;
            end
            out_data_nxt.busy_res        = 1'b1;
            out_data_nxt.run_id          = best_r.job;
            out_data_nxt.switched        = !prev_known_r || (prev_job_r != best_r.job);
            out_data_nxt.first_run       = !best_r.started;
            out_data_nxt.finished        = (rem_new == '0);
            out_data_nxt.remaining_after = rem_new;
            prev_job_nxt                 = best_r.job;
            prev_known_nxt               = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      rd_v_r       <= 1'b0;
      found_r      <= 1'b0;
      valid_r      <= '0;
      prev_job_r   <= '0;
      prev_known_r <= 1'b0;
      quantum_r    <= srtf_pkg::SLICE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      rd_v_r       <= rd_v_nxt;
      found_r      <= found_nxt;
      valid_r      <= valid_nxt;
      prev_job_r   <= prev_job_nxt;
      prev_known_r <= prev_known_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= idx_r;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      item_job_r  <= in_tdata[srtf_pkg::JOB_W-1:0];
      item_time_r <= in_tdata[srtf_pkg::JOB_W +: srtf_pkg::TIME_W];
    end
  end

`ifndef NO_ASSERTIONS
  // A finished job must also be reported as having run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.finished |-> out_data_r.busy_res)
    else $error("finished reported without a running job");

  // An arrival result never carries tick fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.accepted |-> !out_data_r.busy_res)
    else $error("arrival result carries tick fields");

  // The table is written only while a result is being produced.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (can_out && ((state_r == ST_A_DONE) || (state_r == ST_T_DONE))))
    else $error("table written outside a completion step");

  // A job that reaches zero frees its slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_DONE) && can_out && found_r && (rem_new == '0)
      |=> !valid_r[$past(best_idx_r)])
    else $error("finished job still holds its slot");

  // A stored arrival occupies its slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_A_DONE) && can_out && found_r |=> valid_r[$past(best_idx_r)])
    else $error("stored arrival does not occupy its slot");
`endif

endmodule

### tb/sv/shortest_remaining_time_scheduler_core_tb.sv
// Testbench for shortest_remaining_time_scheduler_core: drives arrival and tick words,
// predicts each result word from a job table kept in a scoreboard class and checks it.
// Depends on srtf_pkg and the core RTL.
module shortest_remaining_time_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srtf_pkg::*;

  class sched_scoreboard;
    bit                 slot_used [SLOTS_DEF];
    logic [JOB_W-1:0]   slot_id   [SLOTS_DEF];
    logic [TIME_W-1:0]  slot_left [SLOTS_DEF];
    bit                 slot_ran  [SLOTS_DEF];
    logic [JOB_W-1:0]   last_run_id;
    bit                 last_run_known;
    logic [SLICE_W-1:0] slice;
    srtf_result_t       predicted_results[$];
    int                 errors;

    function new();
      foreach (slot_used[k]) begin
        slot_used[k] = 1'b0;
        slot_id[k]   = '0;
        slot_left[k] = '0;
        slot_ran[k]  = 1'b0;
      end
      last_run_id    = '0;
      last_run_known = 1'b0;
      slice          = SLICE_RESET;
      errors         = 0;
    endfunction

    function void set_slice(logic [SLICE_W-1:0] value);
      slice = value;
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction

    function srtf_result_t predict_schedule(logic func, logic [JOB_W-1:0] id,
                                            logic [TIME_W-1:0] rt);
      srtf_result_t      res;
      int                pick;
      logic [TIME_W-1:0] left;
      res  = '0;
      pick = -1;
      if (func == FUNC_ARRIVAL) begin
        // The lowest free slot takes the job; a full table refuses it.
        for (int k = 0; k < SLOTS_DEF; k++) begin
          if (!slot_used[k] && !res.accepted) begin
            slot_used[k] = 1'b1;
            slot_id[k]   = id;
            slot_left[k] = rt;
            slot_ran[k]  = 1'b0;
            res.accepted = 1'b1;
          end
        end
        return res;
      end
      // Strict less-than keeps the lowest slot on a tie.
      for (int k = 0; k < SLOTS_DEF; k++) begin
        if (slot_used[k] && (pick < 0 || slot_left[k] < slot_left[pick])) pick = k;
      end
      if (pick < 0) return res;
      left = (slot_left[pick] > slice) ? slot_left[pick] - slice : '0;
      res.busy_res        = 1'b1;
      res.run_id          = slot_id[pick];
      res.switched        = !last_run_known || (last_run_id != slot_id[pick]);
      res.first_run       = !slot_ran[pick];
      res.remaining_after = left;
      slot_ran[pick]  = 1'b1;
      slot_left[pick] = left;
      if (left == '0) begin
        slot_used[pick] = 1'b0;
        res.finished    = 1'b1;
      end
      last_run_id    = slot_id[pick];
      last_run_known = 1'b1;
      return res;
    endfunction

    function void note_word(logic func, logic [JOB_W-1:0] id, logic [TIME_W-1:0] rt);
      predicted_results.push_back(predict_schedule(func, id, rt));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(srtf_result_t got);
      srtf_result_t want;
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t: result word mismatch, expected none, actual %h", $time, got);
        return;
      end
      want = predicted_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("run_id", want.run_id, got.run_id);
      compare_field("switched", want.switched, got.switched);
      compare_field("first_run", want.first_run, got.first_run);
      compare_field("finished", want.finished, got.finished);
      compare_field("remaining_after", want.remaining_after, got.remaining_after);
      compare_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = FUNC_ARRIVAL;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [SLICE_W-1:0]    cfg_wr_data = '0;

  sched_scoreboard sb = new();
  int in_idle_pct  = 15;
  int out_idle_pct = 15;
  bit hold_req     = 1'b0;

  shortest_remaining_time_scheduler_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: checks each accepted word, then decides the next ready value.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
      if (hold_req) begin
        stall_left = 240;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Valid stays high from one word to the next unless an idle burst comes between.
  task automatic send_word(logic func, logic [JOB_W-1:0] id, logic [TIME_W-1:0] rt);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {rt, id};
    do @(posedge clk); while (!in_tready);
    sb.note_word(func, id, rt);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_slice(value);
  endtask

  // Mostly short jobs so that slots turn over; long and zero run times now and then.
  task automatic random_word(int arrival_pct);
    logic [TIME_W-1:0] rt;
    case ($urandom_range(0, 39))
      0:             rt = '0;
      1:             rt = '1;
      2, 3:          rt = TIME_W'($urandom);
      4, 5, 6, 7, 8: rt = TIME_W'($urandom_range(1, 400));
      default:       rt = TIME_W'($urandom_range(1, 12));
    endcase
    send_word(($urandom_range(0, 99) < arrival_pct) ? FUNC_ARRIVAL : FUNC_TICK,
              JOB_W'($urandom), rt);
  endtask

  initial begin : stimulus
    int                 pct;
    logic [SLICE_W-1:0] slices [7];
    slices    = '{8'd255, 8'd1, 8'd0, 8'd255, 8'd7, 8'd128, 8'd1};
    slices[4] = SLICE_W'($urandom_range(2, 254));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the slice left at its reset value.
    send_word(FUNC_TICK, 8'hFF, 16'hFFFF);      // nothing to run
    send_word(FUNC_ARRIVAL, 8'h00, 16'h0000);   // zero run time
    send_word(FUNC_TICK, 8'h00, 16'h0000);
    send_word(FUNC_ARRIVAL, 8'hFF, 16'hFFFF);
    send_word(FUNC_ARRIVAL, 8'h5A, 16'd1);
    send_word(FUNC_ARRIVAL, 8'h5A, 16'd3);      // duplicate id in its own slot
    send_word(FUNC_ARRIVAL, 8'hA5, 16'd3);      // ties with the slot below it
    repeat (5) send_word(FUNC_TICK, 8'h00, 16'h0000);
    write_slice(8'd0);
    send_word(FUNC_TICK, 8'h00, 16'h0000);      // zero slice leaves the job as it was
    send_word(FUNC_ARRIVAL, 8'h33, 16'h0000);
    send_word(FUNC_TICK, 8'h00, 16'h0000);
    write_slice(8'd255);
    send_word(FUNC_TICK, 8'h00, 16'h0000);
    send_word(FUNC_TICK, 8'h00, 16'h0000);

    foreach (slices[p]) begin
      write_slice(slices[p]);
      if (p == $size(slices) - 1) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      // Fill the table, with refusals once it is full.
      repeat (18) random_word(100);
      if (p == 1) begin
        // Long receiver hold-off while words keep coming, so the input backs up.
        pct         = in_idle_pct;
        in_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (10) random_word(50);
        in_idle_pct = pct;
      end
      pct = $urandom_range(30, 70);
      repeat (80) random_word(pct);
      repeat (20) random_word(10);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
